@@ design/rau_pkg.sv @@
// Package with shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int W = 64;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_GCD,
    OP_DIV,
    OP_MUL,
    OP_ADDSUB,
    OP_NEG
  } op_t;

  typedef struct packed {
    logic start;
    op_t op;
    logic [2:0] sa;
    logic [2:0] sb;
    logic [2:0] dst;
    logic sub;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } dp_sts_t;

  // Register file slots.
  localparam logic [2:0] R_AN = 3'd0;
  localparam logic [2:0] R_AD = 3'd1;
  localparam logic [2:0] R_BN = 3'd2;
  localparam logic [2:0] R_BD = 3'd3;
  localparam logic [2:0] R_G1 = 3'd4;
  localparam logic [2:0] R_G2 = 3'd5;
  localparam logic [2:0] R_T1 = 3'd6;
  localparam logic [2:0] R_T2 = 3'd7;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction
endpackage

@@ design/rau_datapath.sv @@
// Datapath: register file, shift-subtract divider (also used for gcd), shift-add multiplier, adder and sign negation.
`timescale 1ns / 1ps
module rau_datapath (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic [63:0] in_an,
  input  logic [63:0] in_ad,
  input  logic [63:0] in_bn,
  input  logic [63:0] in_bd,
  input  rau_pkg::dp_cmd_t cmd,
  output rau_pkg::dp_sts_t sts,
  output logic [63:0] r0,
  output logic [63:0] r1
);
  import rau_pkg::*;

  logic [W-1:0] rf [8];
  logic busy;
  op_t op;
  logic [2:0] dst;
  logic [6:0] cnt;
  logic [W-1:0] x, y;
  logic [W-1:0] rem, quo;
  logic [W:0] acc_hi;
  logic [W-1:0] acc_lo;
  logic xneg;
  logic [W:0] trial;
  logic [W-1:0] opa, opb, sum;
  logic done_r, ovf_r;
  logic [W:0] addp;
  logic [2*W-1:0] prod;
  logic pneg;
  logic [W:0] plimit;

  assign opa = rf[cmd.sa];
  assign opb = rf[cmd.sb];
  assign sum = cmd.sub ? (opa - opb) : (opa + opb);
  assign trial = {rem[W-1:0], quo[W-1]} - {1'b0, y};
  assign addp = acc_lo[0] ? ({1'b0, acc_hi[W-1:0]} + {1'b0, x}) : {1'b0, acc_hi[W-1:0]};
  assign prod = {acc_hi[W-1:0], acc_lo};
  assign plimit = pneg ? {1'b0, 1'b1, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};

  assign r0 = rf[R_T1];
  assign r1 = rf[R_T2];
  assign sts.done = done_r;
  assign sts.ovf = ovf_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      ovf_r <= 1'b0;
    end else if (load) begin
      rf[R_AN] <= in_an;
      rf[R_AD] <= in_ad;
      rf[R_BN] <= in_bn;
      rf[R_BD] <= in_bd;
      ovf_r <= 1'b0;
    end else if (cmd.start) begin
      op <= cmd.op;
      dst <= cmd.dst;
      unique case (cmd.op)
        OP_GCD: begin
          x <= mag(opa);
          y <= mag(opb);
          busy <= 1'b1;
          cnt <= '0;
          rem <= '0;
          quo <= mag(opa);
        end
        OP_DIV: begin
          xneg <= opa[W-1];
          y <= opb;
          rem <= '0;
          quo <= mag(opa);
          cnt <= '0;
          busy <= 1'b1;
        end
        OP_MUL: begin
          x <= mag(opa);
          acc_lo <= mag(opb);
          acc_hi <= '0;
          pneg <= (opa[W-1] ^ opb[W-1]) && (opa != '0) && (opb != '0);
          cnt <= '0;
          busy <= 1'b1;
        end
        OP_ADDSUB: begin
          rf[cmd.dst] <= sum;
          if (cmd.sub ? ((opa[W-1] ^ opb[W-1]) & (opa[W-1] ^ sum[W-1]))
                      : (~(opa[W-1] ^ opb[W-1]) & (opa[W-1] ^ sum[W-1])))
            ovf_r <= 1'b1;
          done_r <= 1'b1;
        end
        OP_NEG: begin
          if (opb[W-1]) begin
            if (opa == {1'b1, {(W-1){1'b0}}} || opb == {1'b1, {(W-1){1'b0}}})
              ovf_r <= 1'b1;
            rf[R_T1] <= ~opa + 1'b1;
            rf[R_T2] <= ~opb + 1'b1;
          end
          done_r <= 1'b1;
        end
        default: done_r <= 1'b1;
      endcase
    end else if (busy) begin
      unique case (op)
        OP_GCD: begin
          // One remainder bit per cycle; a new Euclid step after each full division.
          if (y == '0) begin
            rf[dst] <= x;
            busy <= 1'b0;
            done_r <= 1'b1;
          end else if (cnt == 7'd64) begin
            x <= y;
            y <= rem;
            quo <= y;
            rem <= '0;
            cnt <= '0;
          end else begin
            cnt <= cnt + 7'd1;
            quo <= {quo[W-2:0], ~trial[W]};
            rem <= trial[W] ? {rem[W-2:0], quo[W-1]} : trial[W-1:0];
          end
        end
        OP_DIV: begin
          if (cnt == 7'd64) begin
            rf[dst] <= xneg ? (~quo + 1'b1) : quo;
            busy <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt <= cnt + 7'd1;
            quo <= {quo[W-2:0], ~trial[W]};
            rem <= trial[W] ? {rem[W-2:0], quo[W-1]} : trial[W-1:0];
          end
        end
        OP_MUL: begin
          if (cnt == 7'd64) begin
            if (acc_hi[W-1:0] != '0 || {1'b0, prod[W-1:0]} > plimit) ovf_r <= 1'b1;
            rf[dst] <= pneg ? (~prod[W-1:0] + 1'b1) : prod[W-1:0];
            busy <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt <= cnt + 7'd1;
            acc_hi <= {1'b0, addp[W:1]};
            acc_lo <= {addp[0], acc_lo[W-1:1]};
          end
        end
        default: busy <= 1'b0;
      endcase
    end
  end
endmodule

@@ design/rau_ctrl.sv @@
// Controller: sequences the datapath operations for one transaction.
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [1:0] op_code,
  input  logic zero_err,
  input  logic t1_zero,
  input  rau_pkg::dp_sts_t sts,
  output rau_pkg::dp_cmd_t cmd,
  output logic finish,
  output logic [1:0] status
);
  import rau_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_t;
  state_t state;
  logic [4:0] step;
  logic [1:0] opc;

  // Program: the datapath command for each step of the operation.
  function automatic dp_cmd_t prog(input logic [1:0] c, input logic [4:0] s);
    dp_cmd_t p;
    p = '0;
    p.start = 1'b1;
    if (c == CMD_ADD || c == CMD_SUB) begin
      unique case (s)
        5'd0: begin p.op = OP_GCD; p.sa = R_AD; p.sb = R_BD; p.dst = R_G1; end
        5'd1: begin p.op = OP_DIV; p.sa = R_AD; p.sb = R_G1; p.dst = R_G2; end
        5'd2: begin p.op = OP_DIV; p.sa = R_BD; p.sb = R_G1; p.dst = R_G1; end
        5'd3: begin p.op = OP_MUL; p.sa = R_AN; p.sb = R_G1; p.dst = R_T1; end
        5'd4: begin p.op = OP_MUL; p.sa = R_BN; p.sb = R_G2; p.dst = R_T2; end
        5'd5: begin
          p.op = OP_ADDSUB; p.sa = R_T1; p.sb = R_T2; p.dst = R_T1;
          p.sub = (c == CMD_SUB);
        end
        default: begin p.op = OP_MUL; p.sa = R_AD; p.sb = R_G1; p.dst = R_T2; end
      endcase
    end else begin
      unique case (s)
        5'd0: begin p.op = OP_GCD; p.sa = R_AN; p.dst = R_G1;
          p.sb = (c == CMD_MUL) ? R_BD : R_BN; end
        5'd1: begin p.op = OP_GCD; p.sa = (c == CMD_MUL) ? R_BN : R_AD;
          p.sb = (c == CMD_MUL) ? R_AD : R_BD; p.dst = R_G2; end
        5'd2: begin p.op = OP_DIV; p.sa = R_AN; p.sb = R_G1; p.dst = R_AN; end
        5'd3: begin p.op = OP_DIV; p.sa = (c == CMD_MUL) ? R_BN : R_BD;
          p.sb = R_G2; p.dst = R_T1; end
        5'd4: begin p.op = OP_DIV; p.sa = R_AD; p.sb = R_G2; p.dst = R_AD; end
        5'd5: begin p.op = OP_DIV; p.sa = (c == CMD_MUL) ? R_BD : R_BN;
          p.sb = R_G1; p.dst = R_T2; end
        5'd6: begin p.op = OP_MUL; p.sa = R_AN; p.sb = R_T1; p.dst = R_T1; end
        default: begin p.op = OP_MUL; p.sa = R_AD; p.sb = R_T2; p.dst = R_T2; end
      endcase
    end
    return p;
  endfunction

  // Reduction tail: gcd, two divides, then the sign fix.
  function automatic dp_cmd_t tail(input logic [4:0] s);
    dp_cmd_t p;
    p = '0;
    p.start = 1'b1;
    unique case (s)
      5'd8: begin p.op = OP_GCD; p.sa = R_T1; p.sb = R_T2; p.dst = R_G1; end
      5'd9: begin p.op = OP_DIV; p.sa = R_T1; p.sb = R_G1; p.dst = R_T1; end
      5'd10: begin p.op = OP_DIV; p.sa = R_T2; p.sb = R_G1; p.dst = R_T2; end
      default: begin p.op = OP_NEG; p.sa = R_T1; p.sb = R_T2; p.dst = R_T1; end
    endcase
    return p;
  endfunction

  always_comb begin
    cmd = '0;
    if (state == S_ISSUE) cmd = (step < 5'd8) ? prog(opc, step) : tail(step);
  end

  always_ff @(posedge clk) begin
    finish <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      status <= ST_OK;
      opc <= CMD_ADD;
    end else begin
      unique case (state)
        S_IDLE: if (go) begin
          opc <= op_code;
          step <= '0;
          if (zero_err) begin
            status <= ST_ZERO;
            finish <= 1'b1;
          end else begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: if (sts.done) begin
          if (step == 5'd7) begin
            if (sts.ovf) begin
              status <= ST_OVF; finish <= 1'b1; state <= S_IDLE;
            end else if (t1_zero) begin
              status <= ST_OK; finish <= 1'b1; state <= S_IDLE;
            end else begin
              step <= 5'd8; state <= S_ISSUE;
            end
          end else if (step == 5'd11) begin
            status <= sts.ovf ? ST_OVF : ST_OK;
            finish <= 1'b1;
            state <= S_IDLE;
          end else begin
            step <= step + 5'd1;
            state <= S_ISSUE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !go) else $error("start while busy");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    finish |-> state == S_IDLE || state == S_WAIT) else $error("finish out of sequence");
  a_issue_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |=> state == S_WAIT) else $error("issue not followed by wait");
`endif
endmodule

@@ design/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit.
// Run time depends on the operands and is set by the bit-serial divider,
// used for every Euclid step and every quotient, and by the shift-add multiplier.
// Throughput: one transaction at a time; a zero denominator runs no datapath operation.
// Reset: synchronous, active high; clears the controller and the output valid flag.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [263:0] s_tdata, // cmd, a_num, a_den, b_num, b_den, zero fill
  output logic m_tvalid,
  input  logic m_tready,
  output logic [135:0] m_tdata  // res_num, res_den, status, zero fill
);
  import rau_pkg::*;

  logic busy, go, finish, zero_err, t1_zero;
  logic [1:0] status;
  logic [63:0] r0, r1;
  logic [1:0] opc;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [63:0] an, ad, bn, bd;

  assign opc = s_tdata[1:0];
  assign an = s_tdata[65:2];
  assign ad = s_tdata[129:66];
  assign bn = s_tdata[193:130];
  assign bd = s_tdata[257:194];
  assign s_tready = !busy && !m_tvalid;
  assign go = s_tvalid && s_tready;
  assign zero_err = (ad == '0) || (bd == '0) || (opc == CMD_DIV && bn == '0);
  assign t1_zero = (r0 == '0);

  rau_datapath u_dp (
    .clk(clk), .rst(rst), .load(go), .in_an(an), .in_ad(ad), .in_bn(bn), .in_bd(bd),
    .cmd(cmd), .sts(sts), .r0(r0), .r1(r1)
  );

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(go), .op_code(opc), .zero_err(zero_err),
    .t1_zero(t1_zero), .sts(sts), .cmd(cmd), .finish(finish), .status(status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) busy <= 1'b1;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (finish) begin
        busy <= 1'b0;
        m_tvalid <= 1'b1;
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[129:128] = status;
    if (status == ST_ZERO) begin
      m_tdata[127:0] = '0;
    end else if (status == ST_OK && r0 == '0) begin
      m_tdata[127:64] = 64'd1;
    end else begin
      m_tdata[63:0] = r0;
      m_tdata[127:64] = r1;
    end
  end
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the rational arithmetic unit, with a scoreboard and stream drivers.
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  localparam int N_RANDOM = 880;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic [1:0] status;
  } frac_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] bn;
    logic [63:0] bd;
  } frac_op_t;

  class frac_scoreboard;
    frac_result_t pending[$];
    int errors;
    int checked;
    int per_status[4];

    function logic [63:0] absval(logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
    endfunction

    function logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function logic [63:0] div_exact(logic [63:0] x, logic [63:0] g);
      logic [63:0] q;
      q = absval(x) / g;
      return x[63] ? (~q + 64'd1) : q;
    endfunction

    function logic [63:0] mul_chk(logic [63:0] x, logic [63:0] y, inout logic ov);
      logic signed [127:0] p;
      p = $signed({{64{x[63]}}, x}) * $signed({{64{y[63]}}, y});
      if (p > $signed({64'd0, MAXV}) || p < $signed({{64{1'b1}}, MINV})) ov = 1'b1;
      return p[63:0];
    endfunction

    function frac_result_t compute(frac_op_t op);
      frac_result_t r;
      logic [63:0] n, d, g, g1, g2, adr, bdr, t1, t2, s;
      logic ov;
      ov = 1'b0;
      if (op.ad == 0 || op.bd == 0 || (op.cmd == CMD_DIV && op.bn == 0)) begin
        r.num = 0;
        r.den = 0;
        r.status = ST_ZERO;
        return r;
      end
      case (op.cmd)
        CMD_ADD, CMD_SUB: begin
          g = gcd64(absval(op.ad), absval(op.bd));
          adr = div_exact(op.ad, g);
          bdr = div_exact(op.bd, g);
          t1 = mul_chk(op.an, bdr, ov);
          t2 = mul_chk(op.bn, adr, ov);
          if (op.cmd == CMD_ADD) begin
            s = t1 + t2;
            if (~(t1[63] ^ t2[63]) & (t1[63] ^ s[63])) ov = 1'b1;
          end else begin
            s = t1 - t2;
            if ((t1[63] ^ t2[63]) & (t1[63] ^ s[63])) ov = 1'b1;
          end
          n = s;
          d = mul_chk(op.ad, bdr, ov);
        end
        CMD_MUL: begin
          g1 = gcd64(absval(op.an), absval(op.bd));
          g2 = gcd64(absval(op.bn), absval(op.ad));
          n = mul_chk(div_exact(op.an, g1), div_exact(op.bn, g2), ov);
          d = mul_chk(div_exact(op.ad, g2), div_exact(op.bd, g1), ov);
        end
        default: begin
          g1 = gcd64(absval(op.an), absval(op.bn));
          g2 = gcd64(absval(op.ad), absval(op.bd));
          n = mul_chk(div_exact(op.an, g1), div_exact(op.bd, g2), ov);
          d = mul_chk(div_exact(op.ad, g2), div_exact(op.bn, g1), ov);
        end
      endcase
      if (ov) begin
        r.num = n;
        r.den = d;
        r.status = ST_OVF;
        return r;
      end
      if (n == 0) begin
        r.num = 0;
        r.den = 1;
        r.status = ST_OK;
        return r;
      end
      g = gcd64(absval(n), absval(d));
      if (g == 0) g = 1;
      n = div_exact(n, g);
      d = div_exact(d, g);
      if (d[63]) begin
        if (n == MINV || d == MINV) ov = 1'b1;
        n = ~n + 64'd1;
        d = ~d + 64'd1;
      end
      r.num = n;
      r.den = d;
      r.status = ov ? ST_OVF : ST_OK;
      return r;
    endfunction

    function void note_input(frac_op_t op);
      pending.push_back(compute(op));
    endfunction

    function void check_result(logic [135:0] data);
      frac_result_t exp_r, got;
      got.num = data[63:0];
      got.den = data[127:64];
      got.status = data[129:128];
      if (pending.size() == 0) begin
        $display("%0t: result with no operation outstanding: %h/%h status %0d",
                 $time, got.num, got.den, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      per_status[exp_r.status]++;
      if (got.num !== exp_r.num) begin
        $display("%0t: res_num expected %h actual %h", $time, exp_r.num, got.num);
        errors++;
      end
      if (got.den !== exp_r.den) begin
        $display("%0t: res_den expected %h actual %h", $time, exp_r.den, got.den);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (data[135:130] !== 6'd0) begin
        $display("%0t: fill bits expected 0 actual %h", $time, data[135:130]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [263:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [135:0] m_tdata;

  frac_scoreboard sb;
  int idle_cycles;
  int sent;
  int dense_gaps;

  rational_arithmetic_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function int draw_wait();
    if (dense_gaps != 0) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function logic [63:0] rand_value(bit nonzero);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 64'($signed($urandom_range(0, 200)) - 100);
      4, 5: v = {{32{1'b0}}, $urandom()} - 64'h8000_0000;
      6: v = {$urandom(), $urandom()};
      7: v = {$urandom(), $urandom()} >> $urandom_range(1, 40);
      8: case ($urandom_range(0, 4))
           0: v = MINV;
           1: v = MAXV;
           2: v = 64'd1;
           3: v = '1;
           default: v = 64'd0;
         endcase
      default: v = 64'($urandom_range(1, 12)) * 64'(1 << $urandom_range(0, 20));
    endcase
    if (nonzero && v == 0) v = 64'd1;
    return v;
  endfunction

  task automatic send_op(frac_op_t op);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, op.bd, op.bn, op.ad, op.an, op.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(op);
    sent++;
  endtask

  task automatic send_fields(logic [1:0] c, logic [63:0] an, logic [63:0] ad,
                             logic [63:0] bn, logic [63:0] bd);
    frac_op_t op;
    op.cmd = c;
    op.an = an;
    op.ad = ad;
    op.bn = bn;
    op.bd = bd;
    send_op(op);
  endtask

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
    end
  end

  initial begin
    frac_op_t op;
    sb = new();
    sent = 0;
    dense_gaps = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fields(CMD_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
    send_fields(CMD_SUB, 64'd1, 64'd2, 64'd1, 64'd2);
    send_fields(CMD_MUL, 64'd6, 64'd35, 64'd14, 64'd9);
    send_fields(CMD_DIV, 64'd3, 64'd4, -64'sd9, 64'd8);
    send_fields(CMD_ADD, 64'd1, 64'd0, 64'd1, 64'd1);
    send_fields(CMD_MUL, 64'd1, 64'd1, 64'd1, 64'd0);
    send_fields(CMD_DIV, 64'd5, 64'd7, 64'd0, 64'd3);
    send_fields(CMD_MUL, MAXV, 64'd1, MAXV, 64'd1);
    send_fields(CMD_ADD, MAXV, 64'd1, 64'd1, 64'd1);
    send_fields(CMD_SUB, MINV, 64'd1, 64'd1, 64'd1);
    send_fields(CMD_MUL, MINV, 64'd1, 64'd1, '1);
    send_fields(CMD_DIV, MINV, 64'd1, '1, 64'd1);
    send_fields(CMD_MUL, MINV, MINV, MINV, MINV);
    send_fields(CMD_DIV, MINV, MAXV, MAXV, MINV);
    send_fields(CMD_ADD, 64'd3, -64'sd4, 64'd5, -64'sd6);
    send_fields(CMD_SUB, -64'sd7, 64'd10, 64'd0, 64'd3);
    send_fields(CMD_MUL, 64'd0, -64'sd5, 64'd9, 64'd2);
    send_fields(CMD_ADD, 64'd1, MINV, 64'd1, MINV);
    send_fields(CMD_DIV, '1, MAXV, '1, MAXV);
    send_fields(CMD_SUB, MAXV, '1, MINV, 64'd1);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) dense_gaps = ($urandom_range(0, 3) == 0);
      op.cmd = 2'($urandom_range(0, 3));
      op.an = rand_value(1'b0);
      op.bn = rand_value(1'b0);
      op.ad = rand_value($urandom_range(0, 19) != 0);
      op.bd = rand_value($urandom_range(0, 19) != 0);
      send_op(op);
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d operations over all four commands, %0d results checked.",
             sent, sb.checked);
    $display("Status mix: %0d ok, %0d zero denominator, %0d overflow.",
             sb.per_status[ST_OK], sb.per_status[ST_ZERO], sb.per_status[ST_OVF]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
